// ===== rtl/core/i2cms_pkg.sv =====
package i2cms_pkg;

	// op codes carried in s_tuser
	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_WRITE_BYTE = 2'd1;
	localparam logic [1:0] OP_WRITE_REG  = 2'd2;
	localparam logic [1:0] OP_READ_WORD  = 2'd3;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  device_address;
		logic [7:0]  register_index;
		logic [15:0] write_word;
		logic        sda_in;
	} cmd_t;

	typedef struct packed {
		logic        command_rejected;
		logic [15:0] read_word;
		logic        done_res;
		logic        busy_res;
		logic        sda_drive;
		logic        sda_level;
		logic        scl_level;
	} res_t;

endpackage

// ===== rtl/core/i2cms_sequencer.sv =====
module i2cms_sequencer
	import i2cms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  cmd_t       cmd,
	input  logic [7:0] half_period_ticks,
	output res_t       res
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_START_A, ST_START_B, ST_START_C,
		ST_WBIT_HI, ST_WBIT_LO, ST_SACK_HI, ST_SACK_LO,
		ST_RBIT_HI, ST_RBIT_LO, ST_MACK_HI, ST_MACK_LO,
		ST_STOP_A, ST_STOP_B, ST_STOP_C
	} step_t;

	step_t       step_q, n_step, tgt;
	logic [2:0]  bit_q, n_bit;
	logic [7:0]  wait_q, n_wait;
	logic [7:0]  shift_q, n_shift;
	logic [1:0]  kind_q, n_kind;
	logic [7:0]  reg_q, n_reg;
	logic [15:0] word_q, n_word;
	logic [15:0] asm_q, n_asm;
	logic [1:0]  byte_q, n_byte;
	logic        scl_q, n_scl, sda_q, n_sda, sden_q, n_sden;
	logic        go, done, rej, busy;
	logic [2:0]  total;

	always_comb begin
		n_step  = step_q;
		n_bit   = bit_q;
		n_wait  = wait_q;
		n_shift = shift_q;
		n_kind  = kind_q;
		n_reg   = reg_q;
		n_word  = word_q;
		n_asm   = asm_q;
		n_byte  = byte_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_sden  = sden_q;
		go      = 1'b0;
		tgt     = ST_IDLE;
		done    = 1'b0;
		rej     = 1'b0;
		busy    = (step_q != ST_IDLE);
		total   = (kind_q == OP_WRITE_BYTE) ? 3'd2 : 3'd4;

		if (!busy) begin
			if (cmd.op != OP_TICK) begin
				n_kind  = cmd.op;
				n_reg   = cmd.register_index;
				n_word  = cmd.write_word;
				n_byte  = 2'd0;
				n_bit   = 3'd0;
				n_shift = {cmd.device_address, cmd.op == OP_READ_WORD};
				go      = 1'b1;
				tgt     = ST_START_A;
			end
		end else begin
			rej = (cmd.op != OP_TICK);
			if (wait_q != 8'd0) begin
				n_wait = wait_q - 8'd1;
			end else begin
				unique case (step_q)
					ST_START_A: begin go = 1'b1; tgt = ST_START_B; end
					ST_START_B: begin go = 1'b1; tgt = ST_START_C; end
					ST_START_C: begin
						n_bit = 3'd0;
						go = 1'b1; tgt = ST_WBIT_HI;
					end
					ST_WBIT_HI: begin go = 1'b1; tgt = ST_WBIT_LO; end
					ST_WBIT_LO: begin
						n_shift = {shift_q[6:0], 1'b0};
						go = 1'b1;
						if (bit_q == 3'd7) begin
							n_bit = 3'd0; tgt = ST_SACK_HI;
						end else begin
							n_bit = bit_q + 3'd1; tgt = ST_WBIT_HI;
						end
					end
					ST_SACK_HI: begin go = 1'b1; tgt = ST_SACK_LO; end
					ST_SACK_LO: begin
						n_byte = byte_q + 2'd1;
						go = 1'b1;
						if (kind_q == OP_READ_WORD) begin
							n_bit = 3'd0; n_shift = 8'd0; tgt = ST_RBIT_HI;
						end else if (n_byte != 2'd0 && {1'b0, n_byte} < total) begin
							// next byte to send: register index, then word high, then low
							priority if (kind_q == OP_WRITE_BYTE) begin
								n_shift = word_q[7:0];
							end else if (n_byte == 2'd1) begin
								n_shift = reg_q;
							end else if (n_byte == 2'd2) begin
								n_shift = word_q[15:8];
							end else begin
								n_shift = word_q[7:0];
							end
							n_bit = 3'd0;
							tgt = ST_WBIT_HI;
						end else begin
							tgt = ST_STOP_A;
						end
					end
					ST_RBIT_HI: begin
						n_shift = {shift_q[6:0], cmd.sda_in};
						go = 1'b1; tgt = ST_RBIT_LO;
					end
					ST_RBIT_LO: begin
						go = 1'b1;
						if (bit_q == 3'd7) begin
							n_bit = 3'd0;
							if (byte_q == 2'd1) n_word = {shift_q, 8'd0};
							else n_asm = {word_q[15:8], shift_q};
							tgt = ST_MACK_HI;
						end else begin
							n_bit = bit_q + 3'd1; tgt = ST_RBIT_HI;
						end
					end
					ST_MACK_HI: begin go = 1'b1; tgt = ST_MACK_LO; end
					ST_MACK_LO: begin
						go = 1'b1;
						if (byte_q == 2'd1) begin
							n_byte = 2'd2; n_bit = 3'd0; n_shift = 8'd0;
							tgt = ST_RBIT_HI;
						end else begin
							tgt = ST_STOP_A;
						end
					end
					ST_STOP_A: begin go = 1'b1; tgt = ST_STOP_B; end
					ST_STOP_B: begin go = 1'b1; tgt = ST_STOP_C; end
					ST_STOP_C: begin
						n_step = ST_IDLE; n_wait = 8'd0; done = 1'b1;
					end
					default: begin n_step = ST_IDLE; n_wait = 8'd0; end
				endcase
			end
		end

		// phase entry: reload the wait and set the pins for the new phase
		if (go) begin
			n_step = tgt;
			n_wait = half_period_ticks;
			unique case (tgt)
				ST_START_A: begin n_sden = 1'b1; n_sda = 1'b1; n_scl = 1'b1; end
				ST_START_B: n_sda = 1'b0;
				ST_WBIT_HI: begin n_sden = 1'b1; n_sda = n_shift[7]; n_scl = 1'b1; end
				ST_SACK_HI: n_scl = 1'b1;
				ST_RBIT_HI: begin n_sden = 1'b0; n_scl = 1'b1; end
				ST_MACK_HI: begin
					n_sden = 1'b1; n_sda = (n_byte != 2'd1); n_scl = 1'b1;
				end
				ST_STOP_A: begin n_sden = 1'b1; n_sda = 1'b0; end
				ST_STOP_B: n_scl = 1'b1;
				ST_STOP_C: n_sda = 1'b1;
				ST_START_C, ST_WBIT_LO, ST_SACK_LO, ST_RBIT_LO, ST_MACK_LO: n_scl = 1'b0;
				default: begin n_step = ST_IDLE; n_wait = 8'd0; end
			endcase
		end

		res.scl_level        = n_scl;
		res.sda_level        = n_sda;
		res.sda_drive        = n_sden;
		res.busy_res         = (n_step != ST_IDLE);
		res.done_res         = done;
		res.read_word        = n_asm;
		res.command_rejected = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			bit_q   <= '0;
			wait_q  <= '0;
			shift_q <= '0;
			kind_q  <= '0;
			reg_q   <= '0;
			word_q  <= '0;
			asm_q   <= '0;
			byte_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			sden_q  <= 1'b1;
		end else if (en) begin
			step_q  <= n_step;
			bit_q   <= n_bit;
			wait_q  <= n_wait;
			shift_q <= n_shift;
			kind_q  <= n_kind;
			reg_q   <= n_reg;
			word_q  <= n_word;
			asm_q   <= n_asm;
			byte_q  <= n_byte;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			sden_q  <= n_sden;
		end
	end

endmodule

// ===== rtl/core/i2c_master_transaction_sequencer_unit.sv =====
// I2C master transaction sequencer.
// Each input word is one bus tick: s_tuser carries the op (0 tick only,
// 1 write byte, 2 write register + 16-bit word, 3 read 16-bit word) and
// s_tdata the address, register, write data and the sampled SDA level.
// Every accepted word yields exactly one output word with the pin levels
// (SCL, SDA, SDA drive), busy, done, the last read word and a reject flag.
// A command arriving while a transaction runs is dropped and flagged.
// half_period_ticks is written through cfg_wr_en/cfg_wr_data; write it only
// while the block is idle. Each bus phase lasts 1 + half_period_ticks ticks.
// An input word passes through the input register, then the result register
// behind the sequencer logic, before it leaves as the output word.
// Throughput: one word per cycle while m_tready is high; the sequencer
// step is a single pass of logic from the input register into the state
// and result registers. When m_tready is low the result word holds, the
// input register fills and then s_tready drops; nothing is lost or repeated.
// Reset: no words in flight, sequencer idle, SCL and SDA released high with
// SDA driven, half_period_ticks back to 1.
module i2c_master_transaction_sequencer_unit
	import i2cms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [6:0] device_address, [14:7] register_index, [30:15] write_word, [31] sda_in
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] op
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
	// [20:5] read_word, [21] command_rejected, [23:22] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_wr_en,
	input  logic [7:0]            cfg_wr_data
);

	logic       valid_s1;
	cmd_t       cmd_s1;
	logic       adv;
	logic       res_valid_q;
	res_t       res_q;
	res_t       res_next;
	logic [7:0] half_q;

	// step the sequencer when an input word waits and the result slot is free
	assign adv      = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1.op             <= s_tuser;
			cmd_s1.device_address <= s_tdata[6:0];
			cmd_s1.register_index <= s_tdata[14:7];
			cmd_s1.write_word     <= s_tdata[30:15];
			cmd_s1.sda_in         <= s_tdata[31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RESET;
		end else if (cfg_wr_en) begin
			half_q <= cfg_wr_data;
		end
	end

	i2cms_sequencer u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (adv),
		.cmd               (cmd_s1),
		.half_period_ticks (half_q),
		.res               (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res_q};

endmodule

// ===== rtl/core/i2cms_checker.sv =====
module i2cms_checker
	import i2cms_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// stop completion leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[3])
		else $error("done reported while still busy");

	// SDA is released only inside a read transaction
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[3])
		else $error("SDA released while idle");

	// a dropped command only happens during a transaction or on its last tick
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[21] |-> (m_tdata[3] || m_tdata[4]))
		else $error("command rejected while idle");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed under stall");

endmodule

bind i2c_master_transaction_sequencer_unit i2cms_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb_i2c_master_transaction_sequencer_unit.sv =====
module tb_i2c_master_transaction_sequencer_unit;
	import i2cms_pkg::*;

	// run ends here no matter what; the slowest legal run is well under this
	localparam int CYCLE_LIMIT = 500_000;

	// sequencer phases, one per bus half-bit (mirrors the block's step numbering)
	typedef enum logic [5:0] {
		PH_IDLE    = 6'd0,
		PH_START_A = 6'd1,
		PH_START_B = 6'd2,
		PH_START_C = 6'd3,
		PH_WBIT_HI = 6'd4,
		PH_WBIT_LO = 6'd5,
		PH_SACK_HI = 6'd6,
		PH_SACK_LO = 6'd7,
		PH_RBIT_HI = 6'd8,
		PH_RBIT_LO = 6'd9,
		PH_MACK_HI = 6'd10,
		PH_MACK_LO = 6'd11,
		PH_STOP_A  = 6'd12,
		PH_STOP_B  = 6'd13,
		PH_STOP_C  = 6'd14
	} phase_e;

	// how SDA is fed while a transaction is run out
	typedef enum int {NO_DRAIN, SDA_RANDOM, SDA_HIGH, SDA_LOW} drain_e;

	typedef struct {
		cmd_t       cmd;
		bit         typed;    // want holds a hand-written status word
		res_t       want;
		drain_e     drain;    // run the transaction out after this word
		logic [1:0] clash_op; // op sent on the tick that completes stop
	} stim_row_t;

	// status words that can be read straight off the spec
	localparam res_t RES_IDLE = '{command_rejected: 1'b0, read_word: 16'h0000,
		done_res: 1'b0, busy_res: 1'b0, sda_drive: 1'b1, sda_level: 1'b1, scl_level: 1'b1};
	localparam res_t RES_START = '{command_rejected: 1'b0, read_word: 16'h0000,
		done_res: 1'b0, busy_res: 1'b1, sda_drive: 1'b1, sda_level: 1'b1, scl_level: 1'b1};
	localparam res_t RES_START_REJ = '{command_rejected: 1'b1, read_word: 16'h0000,
		done_res: 1'b0, busy_res: 1'b1, sda_drive: 1'b1, sda_level: 1'b1, scl_level: 1'b1};
	// SDA falls with SCL high: second start phase
	localparam res_t RES_START_B_REJ = '{command_rejected: 1'b1, read_word: 16'h0000,
		done_res: 1'b0, busy_res: 1'b1, sda_drive: 1'b1, sda_level: 1'b0, scl_level: 1'b1};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// [6:0] device_address, [14:7] register_index, [30:15] write_word, [31] sda_in
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// [1:0] op
	logic [1:0]            s_tuser = OP_TICK;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
	// [20:5] read_word, [21] command_rejected, [23:22] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_wr_en = 1'b0;
	logic [7:0]            cfg_wr_data = '0;

	i2c_master_transaction_sequencer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// bus sequencer shadow: same state as the block, stepped per word
	// ---------------------------------------------------------------
	logic [7:0]  half_ticks = HALF_PERIOD_RESET;
	phase_e      bus_phase = PH_IDLE;
	logic [2:0]  bit_cnt = '0;
	logic [7:0]  wait_cnt = '0;
	logic [7:0]  shift_q = '0;
	logic [1:0]  kind_q = OP_TICK;
	logic [7:0]  reg_q = '0;
	logic [15:0] word_q = '0;    // write data; upper byte reused for the first read byte
	logic [15:0] rd_word_q = '0;
	logic [1:0]  byte_idx = '0;  // bytes finished in this transaction, wraps at 4
	logic        scl_q = 1'b1;
	logic        sda_q = 1'b1;
	logic        sda_oe = 1'b1;

	res_t status_words_q[$];     // status words still owed by the block

	int items_sent;
	int words_checked;
	int mismatch_count;
	int n_started;
	int n_dropped;
	int n_stops;
	int cycle_count;
	int settings_used;
	bit calm;                    // last stretch: no idling on either side
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int stall_left;

	// load a phase: every phase waits half_ticks extra ticks before moving on
	function automatic void enter_phase(phase_e p);
		bus_phase = p;
		wait_cnt = half_ticks;
		case (p)
			PH_START_A: begin
				sda_oe = 1'b1;
				sda_q = 1'b1;
				scl_q = 1'b1;
			end
			PH_START_B: sda_q = 1'b0;
			PH_WBIT_HI: begin
				sda_oe = 1'b1;
				sda_q = shift_q[7];
				scl_q = 1'b1;
			end
			// slave ACK slot: SDA stays at the last driven level
			PH_SACK_HI, PH_STOP_B: scl_q = 1'b1;
			PH_RBIT_HI: begin
				sda_oe = 1'b0;
				scl_q = 1'b1;
			end
			// master ACK after first read byte, NACK after second
			PH_MACK_HI: begin
				sda_oe = 1'b1;
				sda_q = (byte_idx == 2'd1) ? 1'b0 : 1'b1;
				scl_q = 1'b1;
			end
			PH_STOP_A: begin
				sda_oe = 1'b1;
				sda_q = 1'b0;
			end
			PH_STOP_C: sda_q = 1'b1;
			PH_START_C, PH_WBIT_LO, PH_SACK_LO, PH_RBIT_LO, PH_MACK_LO: scl_q = 1'b0;
			default: begin
				bus_phase = PH_IDLE;
				wait_cnt = '0;
			end
		endcase
	endfunction

	// end of the current phase; returns 1 when the stop condition completes
	function automatic logic next_phase(logic sda_bit);
		logic [2:0] nbytes;
		logic       fin;
		fin = 1'b0;
		case (bus_phase)
			PH_START_A: enter_phase(PH_START_B);
			PH_START_B: enter_phase(PH_START_C);
			PH_START_C: begin
				bit_cnt = '0;
				enter_phase(PH_WBIT_HI);
			end
			PH_WBIT_HI: enter_phase(PH_WBIT_LO);
			PH_WBIT_LO: begin
				shift_q = shift_q << 1;
				if (bit_cnt == 3'd7) begin
					bit_cnt = '0;
					enter_phase(PH_SACK_HI);
				end else begin
					bit_cnt = bit_cnt + 3'd1;
					enter_phase(PH_WBIT_HI);
				end
			end
			PH_SACK_HI: enter_phase(PH_SACK_LO);
			PH_SACK_LO: begin
				byte_idx = byte_idx + 2'd1;
				if (kind_q == OP_READ_WORD) begin
					bit_cnt = '0;
					shift_q = '0;
					enter_phase(PH_RBIT_HI);
				end else begin
					// address + 1 data byte, or address + register + 2 data bytes
					nbytes = (kind_q == OP_WRITE_BYTE) ? 3'd2 : 3'd4;
					if (byte_idx != 2'd0 && {1'b0, byte_idx} < nbytes) begin
						if (kind_q == OP_WRITE_BYTE || byte_idx == 2'd3)
							shift_q = word_q[7:0];
						else if (byte_idx == 2'd1)
							shift_q = reg_q;
						else
							shift_q = word_q[15:8];
						bit_cnt = '0;
						enter_phase(PH_WBIT_HI);
					end else begin
						enter_phase(PH_STOP_A);
					end
				end
			end
			PH_RBIT_HI: begin
				shift_q = {shift_q[6:0], sda_bit};
				enter_phase(PH_RBIT_LO);
			end
			PH_RBIT_LO: begin
				if (bit_cnt == 3'd7) begin
					bit_cnt = '0;
					if (byte_idx == 2'd1)
						word_q = {shift_q, 8'h00};
					else
						rd_word_q = {word_q[15:8], shift_q};
					enter_phase(PH_MACK_HI);
				end else begin
					bit_cnt = bit_cnt + 3'd1;
					enter_phase(PH_RBIT_HI);
				end
			end
			PH_MACK_HI: enter_phase(PH_MACK_LO);
			PH_MACK_LO: begin
				if (byte_idx == 2'd1) begin
					byte_idx = 2'd2;
					bit_cnt = '0;
					shift_q = '0;
					enter_phase(PH_RBIT_HI);
				end else begin
					enter_phase(PH_STOP_A);
				end
			end
			PH_STOP_A: enter_phase(PH_STOP_B);
			PH_STOP_B: enter_phase(PH_STOP_C);
			PH_STOP_C: begin
				bus_phase = PH_IDLE;
				wait_cnt = '0;
				fin = 1'b1;
			end
			default: begin
				bus_phase = PH_IDLE;
				wait_cnt = '0;
			end
		endcase
		return fin;
	endfunction

	// one bus tick: status word the block must send for this input word
	function automatic res_t step_sequencer(cmd_t c);
		res_t r;
		logic done;
		r = '0;
		done = 1'b0;
		if (bus_phase == PH_IDLE) begin
			// idle: a command starts at once, start phase visible this tick
			if (c.op != OP_TICK) begin
				kind_q = c.op;
				reg_q = c.register_index;
				word_q = c.write_word;
				byte_idx = '0;
				bit_cnt = '0;
				shift_q = {c.device_address, c.op == OP_READ_WORD};
				enter_phase(PH_START_A);
				n_started++;
			end
		end else begin
			// busy counts from the start of the tick, so the done tick drops too
			if (c.op != OP_TICK) begin
				r.command_rejected = 1'b1;
				n_dropped++;
			end
			if (wait_cnt != 8'd0)
				wait_cnt = wait_cnt - 8'd1;
			else
				done = next_phase(c.sda_in);
		end
		if (done)
			n_stops++;
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.sda_drive = sda_oe;
		r.busy_res = (bus_phase != PH_IDLE);
		r.done_res = done;
		r.read_word = rd_word_q;
		return r;
	endfunction

	function automatic cmd_t random_cmd(logic [1:0] op);
		cmd_t c;
		c.op = op;
		c.device_address = 7'($urandom);
		c.register_index = 8'($urandom);
		c.write_word = 16'($urandom);
		c.sda_in = 1'($urandom);
		return c;
	endfunction

	function automatic stim_row_t stim_row(logic [1:0] op, logic [6:0] addr,
			logic [7:0] regi, logic [15:0] wdata, logic sda, drain_e drain,
			logic [1:0] clash_op, bit typed, res_t want);
		stim_row_t row;
		row.cmd = '{op: op, device_address: addr, register_index: regi,
			write_word: wdata, sda_in: sda};
		row.drain = drain;
		row.clash_op = clash_op;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// queue the status word this tick owes, then hand the word over
	task automatic drive_word(cmd_t c, bit typed, res_t want);
		res_t predicted;
		predicted = step_sequencer(c);
		status_words_q.push_back(typed ? want : predicted);
		// sometimes an idle gap with s_tvalid low ahead of this word
		if (tx_idle_on && !calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.op;
		s_tdata <= {c.sda_in, c.write_word, c.register_index, c.device_address};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// feed plain ticks until the transaction in flight has finished;
	// noise_pct of them carry a command that must be dropped
	task automatic run_to_idle(drain_e mode, logic [1:0] clash_op, int noise_pct);
		cmd_t c;
		while (bus_phase != PH_IDLE) begin
			c = random_cmd(OP_TICK);
			if ($urandom_range(0, 99) < noise_pct)
				c.op = 2'($urandom_range(1, 3));
			if (mode == SDA_HIGH)
				c.sda_in = 1'b1;
			else if (mode == SDA_LOW)
				c.sda_in = 1'b0;
			// next tick completes stop: try to sneak a command in
			if (bus_phase == PH_STOP_C && wait_cnt == 8'd0)
				c.op = clash_op;
			drive_word(c, 1'b0, '0);
		end
	endtask

	// random transactions back to back, a few idle ticks in between
	task automatic run_traffic(int budget);
		int     stop_at;
		cmd_t   c;
		drain_e mode;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			tx_idle_on = ($urandom_range(0, 2) != 0);
			rx_idle_on = ($urandom_range(0, 2) != 0);
			repeat ($urandom_range(0, 3)) drive_word(random_cmd(OP_TICK), 1'b0, '0);
			c = random_cmd(2'($urandom_range(1, 3)));
			drive_word(c, 1'b0, '0);
			case ($urandom_range(0, 5))
				0: mode = SDA_HIGH;
				1: mode = SDA_LOW;
				default: mode = SDA_RANDOM;
			endcase
			run_to_idle(mode, ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : OP_TICK,
				5);
		end
	endtask

	// only with the bus idle and every status word back
	task automatic set_half_period(logic [7:0] v);
		s_tvalid <= 1'b0;
		while (status_words_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		half_ticks = v;
		settings_used++;
	endtask

	stim_row_t directed_rows [15];

	initial begin
		// reset state, command start, drops while busy and on the done tick,
		// address/data extremes, reads with SDA stuck high and low
		directed_rows[0]  = stim_row(OP_TICK, 7'h00, 8'h00, 16'h0000, 1'b0,
			NO_DRAIN, OP_TICK, 1'b1, RES_IDLE);
		directed_rows[1]  = stim_row(OP_TICK, 7'h7f, 8'hff, 16'hffff, 1'b1,
			NO_DRAIN, OP_TICK, 1'b1, RES_IDLE);
		directed_rows[2]  = stim_row(OP_WRITE_BYTE, 7'h7f, 8'hff, 16'hffff, 1'b0,
			NO_DRAIN, OP_TICK, 1'b1, RES_START);
		directed_rows[3]  = stim_row(OP_READ_WORD, 7'h00, 8'h00, 16'h0000, 1'b1,
			NO_DRAIN, OP_TICK, 1'b1, RES_START_REJ);
		directed_rows[4]  = stim_row(OP_WRITE_REG, 7'h55, 8'haa, 16'h5555, 1'b0,
			SDA_RANDOM, OP_WRITE_REG, 1'b1, RES_START_B_REJ);
		directed_rows[5]  = stim_row(OP_WRITE_REG, 7'h00, 8'h00, 16'h0000, 1'b0,
			SDA_HIGH, OP_TICK, 1'b1, RES_START);
		directed_rows[6]  = stim_row(OP_WRITE_REG, 7'h7f, 8'hff, 16'hffff, 1'b1,
			SDA_LOW, OP_READ_WORD, 1'b0, '0);
		directed_rows[7]  = stim_row(OP_WRITE_REG, 7'h2a, 8'h5a, 16'ha55a, 1'b0,
			SDA_RANDOM, OP_TICK, 1'b0, '0);
		directed_rows[8]  = stim_row(OP_READ_WORD, 7'h7f, 8'h00, 16'h0000, 1'b1,
			SDA_HIGH, OP_TICK, 1'b0, '0);
		directed_rows[9]  = stim_row(OP_TICK, 7'h00, 8'h00, 16'h0000, 1'b1,
			NO_DRAIN, OP_TICK, 1'b0, '0);
		directed_rows[10] = stim_row(OP_READ_WORD, 7'h00, 8'hff, 16'hffff, 1'b0,
			SDA_LOW, OP_READ_WORD, 1'b0, '0);
		directed_rows[11] = stim_row(OP_READ_WORD, 7'h2a, 8'h00, 16'h0000, 1'b0,
			SDA_RANDOM, OP_WRITE_BYTE, 1'b0, '0);
		directed_rows[12] = stim_row(OP_WRITE_BYTE, 7'h00, 8'h00, 16'h0000, 1'b0,
			SDA_RANDOM, OP_TICK, 1'b0, '0);
		directed_rows[13] = stim_row(OP_WRITE_BYTE, 7'h55, 8'h33, 16'h12ab, 1'b1,
			SDA_RANDOM, OP_WRITE_BYTE, 1'b0, '0);
		directed_rows[14] = stim_row(OP_TICK, 7'h2a, 8'h55, 16'haaaa, 1'b0,
			NO_DRAIN, OP_TICK, 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass: typed rows at the reset half period, the rest at double speed
		foreach (directed_rows[i]) begin
			if (i == 6)
				set_half_period(8'd0);
			drive_word(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
			if (directed_rows[i].drain != NO_DRAIN)
				run_to_idle(directed_rows[i].drain, directed_rows[i].clash_op, 0);
		end

		// double speed
		run_traffic(100);

		set_half_period(8'd2);
		run_traffic(100);

		// back to reset value, no idling from here on
		set_half_period(HALF_PERIOD_RESET);
		calm = 1'b1;
		run_traffic(100);

		s_tvalid <= 1'b0;
		while (status_words_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("bus ticks sent: %0d, transactions run: %0d, commands dropped: %0d",
			items_sent, n_started, n_dropped);
		$display("stop conditions: %0d, status words checked: %0d, half-period settings: %0d",
			n_stops, words_checked, settings_used + 1);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ---------------------------------------------------------------
	// receiver side: random stall bursts, compare each accepted word
	// ---------------------------------------------------------------
	res_t got_word;
	res_t want_word;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				words_checked++;
				if (status_words_q.size() == 0) begin
					$error("status word %h arrived with nothing outstanding", m_tdata);
					mismatch_count++;
				end else begin
					want_word = status_words_q.pop_front();
					got_word = res_t'(m_tdata[21:0]);
					check_field("scl_level", 16'(want_word.scl_level),
						16'(got_word.scl_level));
					check_field("sda_level", 16'(want_word.sda_level),
						16'(got_word.sda_level));
					check_field("sda_drive", 16'(want_word.sda_drive),
						16'(got_word.sda_drive));
					check_field("busy_res", 16'(want_word.busy_res),
						16'(got_word.busy_res));
					check_field("done_res", 16'(want_word.done_res),
						16'(got_word.done_res));
					check_field("read_word", want_word.read_word, got_word.read_word);
					check_field("command_rejected", 16'(want_word.command_rejected),
						16'(got_word.command_rejected));
					check_field("pad", 16'h0000, 16'(m_tdata[23:22]));
				end
			end
			// stall bursts with m_tready low, none once calm is set
			if (stall_left != 0 && !calm) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_idle_on && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
